// ===== rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Sizes, result kinds and shared types of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int PRICE_LEVELS = 1024;
	localparam int ORDER_SLOTS  = 1024;
	localparam int QTY_BITS     = 20;
	localparam int MAX_FILLS    = 63;
	localparam int ID_BITS      = 32;

	localparam int PRICE_BITS = $clog2(PRICE_LEVELS);
	localparam int SLOT_BITS  = $clog2(ORDER_SLOTS);
	localparam int FCNT_BITS  = SLOT_BITS + 1;
	localparam int LVL_BITS   = PRICE_BITS + 1;
	localparam int FILL_BITS  = $clog2(MAX_FILLS + 1);

	// Level occupancy is kept as a bitmap, one word per memory row.
	localparam int WORD_BITS     = 64;
	localparam int BIT_BITS      = $clog2(WORD_BITS);
	localparam int ROWS_PER_SIDE = PRICE_LEVELS / WORD_BITS;
	localparam int ROW_BITS      = $clog2(ROWS_PER_SIDE);
	localparam int BM_ROWS       = 2 * ROWS_PER_SIDE;
	localparam int BMA_BITS      = ROW_BITS + 1;

	localparam logic [1:0] KIND_TRADE = 2'd0;
	localparam logic [1:0] KIND_REST  = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;
	localparam logic [1:0] KIND_LIMIT = 2'd3;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic                found;
		logic [BIT_BITS-1:0] bit_idx;
	} pick_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0] head;
		logic [SLOT_BITS-1:0] tail;
	} lvl_t;

endpackage

// ===== rtl/lobm_order_if.sv =====
// ----------------------------------------------------------------------------
// Order channel
// Valid/ready channel that carries one incoming limit order per item.
// ----------------------------------------------------------------------------
interface lobm_order_if;
	logic                           valid;
	logic                           ready;
	logic                           side;
	logic [lobm_pkg::PRICE_BITS-1:0] limit_price;
	logic [lobm_pkg::QTY_BITS-1:0]   order_quantity;

	modport source(output valid, side, limit_price, order_quantity, input ready);
	modport sink(input valid, side, limit_price, order_quantity, output ready);
endinterface

// ===== rtl/lobm_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one trade or order outcome per item.
// ----------------------------------------------------------------------------
interface lobm_result_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      kind;
	logic [lobm_pkg::QTY_BITS-1:0]   trade_quantity;
	logic [lobm_pkg::PRICE_BITS-1:0] trade_price;
	logic [lobm_pkg::ID_BITS-1:0]    maker_order_id;
	logic [lobm_pkg::ID_BITS-1:0]    taker_order_id;
	logic [lobm_pkg::QTY_BITS-1:0]   remaining_quantity;
	logic                            last;

	modport source(output valid, kind, trade_quantity, trade_price, maker_order_id,
		taker_order_id, remaining_quantity, last, input ready);
	modport sink(input valid, kind, trade_quantity, trade_price, maker_order_id,
		taker_order_id, remaining_quantity, last, output ready);
endinterface

// ===== rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching of limit orders against a memory-held book.
// ----------------------------------------------------------------------------
// Each fill scans the opposite side's bitmap rows from the best price (1 to 16 rows),
// then reads the level and its head slot and emits a trade. A rest takes a slot and
// sets the level bit or links the old tail before it reports; a book-full drop reports
// from the rest check and a fill-limit drop from the scan. One order is in flight at
// a time; a result stall holds the fill or final state. Reset clears control state at
// once; a clearing pass then zeroes the level bitmap before the first order is taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher (
	input  logic          clk,
	input  logic          arst_n,
	lobm_order_if.sink    orders,
	lobm_result_if.source results
);
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SRD  = 4'd2;
	localparam logic [3:0] S_SCHK = 4'd3;
	localparam logic [3:0] S_LV   = 4'd4;
	localparam logic [3:0] S_SL   = 4'd5;
	localparam logic [3:0] S_RST  = 4'd6;
	localparam logic [3:0] S_RB   = 4'd7;
	localparam logic [3:0] S_RW   = 4'd8;
	localparam logic [3:0] S_RL   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	// Memories: level bitmap, level head/tail, slot fields and the free stack.
	logic [lobm_pkg::WORD_BITS-1:0]  bm_mem  [lobm_pkg::BM_ROWS];
	lobm_pkg::lvl_t                  lv_mem  [2*lobm_pkg::PRICE_LEVELS];
	logic [lobm_pkg::QTY_BITS-1:0]   sq_mem  [lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::ID_BITS-1:0]    sid_mem [lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::SLOT_BITS-1:0]  snx_mem [lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::SLOT_BITS-1:0]  stk_mem [lobm_pkg::ORDER_SLOTS];

	logic [3:0]                      state_q;
	logic [lobm_pkg::BMA_BITS-1:0]   clr_q;
	logic [lobm_pkg::ID_BITS-1:0]    next_id_q;
	logic                            side_q;
	logic [lobm_pkg::PRICE_BITS-1:0] limit_q;
	logic [lobm_pkg::QTY_BITS-1:0]   rem_q;
	logic [lobm_pkg::ID_BITS-1:0]    taker_q;
	logic [lobm_pkg::FILL_BITS-1:0]  nfill_q;
	logic                            bside_q;
	logic [lobm_pkg::ROW_BITS-1:0]   row_q;
	logic [lobm_pkg::WORD_BITS-1:0]  word_q;
	logic [lobm_pkg::BIT_BITS-1:0]   pbit_q;
	logic [lobm_pkg::LVL_BITS-1:0]   lv_q;
	logic [lobm_pkg::SLOT_BITS-1:0]  slot_q;
	logic [lobm_pkg::SLOT_BITS-1:0]  tail_q;
	logic [lobm_pkg::SLOT_BITS-1:0]  nslot_q;
	logic [lobm_pkg::FCNT_BITS-1:0]  stk_cnt_q;
	logic [lobm_pkg::FCNT_BITS-1:0]  fresh_q;
	logic [1:0]                      fin_kind_q;

	logic                            res_valid_q;
	logic [1:0]                      res_kind_q;
	logic [lobm_pkg::QTY_BITS-1:0]   res_tq_q;
	logic [lobm_pkg::PRICE_BITS-1:0] res_tp_q;
	logic [lobm_pkg::ID_BITS-1:0]    res_maker_q;
	logic [lobm_pkg::ID_BITS-1:0]    res_taker_q;
	logic [lobm_pkg::QTY_BITS-1:0]   res_rem_q;
	logic                            res_last_q;

	logic [lobm_pkg::WORD_BITS-1:0]  bm_rdata;
	lobm_pkg::lvl_t                  lv_rdata;
	logic [lobm_pkg::QTY_BITS-1:0]   sq_rdata;
	logic [lobm_pkg::ID_BITS-1:0]    sid_rdata;
	logic [lobm_pkg::SLOT_BITS-1:0]  snx_rdata;
	logic [lobm_pkg::SLOT_BITS-1:0]  stk_rdata;

	lobm_pkg::pick_t                 pick;
	logic                            oslot;
	logic                            res_load;
	logic [lobm_pkg::LVL_BITS-1:0]   own_lv;
	logic [lobm_pkg::LVL_BITS-1:0]   lv_raddr;
	logic [lobm_pkg::SLOT_BITS-1:0]  slot_raddr;
	logic [lobm_pkg::SLOT_BITS-1:0]  stk_raddr;
	logic [lobm_pkg::ROW_BITS-1:0]   start_row;
	logic [lobm_pkg::ROW_BITS-1:0]   lim_row;
	logic [lobm_pkg::QTY_BITS-1:0]   tq;
	logic [lobm_pkg::QTY_BITS-1:0]   new_rem;
	logic [lobm_pkg::QTY_BITS-1:0]   new_sq;
	logic [lobm_pkg::SLOT_BITS-1:0]  ns;
	logic                            book_full;

	// Write ports, one per memory.
	logic                            bm_we;
	logic [lobm_pkg::BMA_BITS-1:0]   bm_wa;
	logic [lobm_pkg::WORD_BITS-1:0]  bm_wd;
	logic                            lv_we;
	logic [lobm_pkg::LVL_BITS-1:0]   lv_wa;
	lobm_pkg::lvl_t                  lv_wd;
	logic                            sq_we;
	logic [lobm_pkg::SLOT_BITS-1:0]  sq_wa;
	logic [lobm_pkg::QTY_BITS-1:0]   sq_wd;
	logic                            sid_we;
	logic                            snx_we;
	logic [lobm_pkg::SLOT_BITS-1:0]  snx_wa;
	logic [lobm_pkg::SLOT_BITS-1:0]  snx_wd;
	logic                            stk_we;

	lobm_bit_pick u_pick (
		.word  (bm_rdata),
		.sell  (side_q),
		.row   (row_q),
		.limit (limit_q),
		.pick  (pick)
	);

	// The result register can take a new item when empty or being emptied.
	assign oslot     = !res_valid_q || results.ready;
	// A trade or a final outcome is loaded into the result register this cycle.
	assign res_load  = ((state_q == S_SL) || (state_q == S_FIN)) && oslot;
	assign own_lv    = {side_q, limit_q};
	assign lim_row   = limit_q[lobm_pkg::PRICE_BITS-1:lobm_pkg::BIT_BITS];
	assign start_row = (side_q == lobm_pkg::SIDE_SELL) ? '1 : '0;
	assign tq        = (sq_rdata < rem_q) ? sq_rdata : rem_q;
	assign new_rem   = rem_q - tq;
	assign new_sq    = sq_rdata - tq;
	assign book_full = (stk_cnt_q == '0) &&
		(fresh_q == lobm_pkg::FCNT_BITS'(lobm_pkg::ORDER_SLOTS));
	assign ns        = (stk_cnt_q != '0) ? stk_rdata : fresh_q[lobm_pkg::SLOT_BITS-1:0];

	// Read addresses are chosen so that they hold steady while a state stalls.
	assign lv_raddr   = (state_q == S_SCHK) ? {~side_q, row_q, pick.bit_idx} : own_lv;
	assign slot_raddr = (state_q == S_LV) ? lv_rdata.head : slot_q;
	assign stk_raddr  = lobm_pkg::SLOT_BITS'(stk_cnt_q - 1'b1);

	always_comb begin
		bm_we  = 1'b0;
		bm_wa  = {bside_q, row_q};
		bm_wd  = word_q & ~(lobm_pkg::WORD_BITS'(1) << pbit_q);
		lv_we  = 1'b0;
		lv_wa  = lv_q;
		lv_wd  = '{head: snx_rdata, tail: tail_q};
		sq_we  = 1'b0;
		sq_wa  = slot_q;
		sq_wd  = new_sq;
		sid_we = 1'b0;
		snx_we = 1'b0;
		snx_wa = ns;
		snx_wd = '0;
		stk_we = 1'b0;
		case (state_q)
			S_CLR: begin
				bm_we = 1'b1;
				bm_wa = clr_q;
				bm_wd = '0;
			end
			S_SL: begin
				if (oslot) begin
					sq_we = 1'b1;
					if (new_sq == '0) begin
						stk_we = 1'b1;
						if (slot_q == tail_q)
							bm_we = 1'b1;
						else
							lv_we = 1'b1;
					end
				end
			end
			S_RB: begin
				sq_we  = 1'b1;
				sq_wa  = ns;
				sq_wd  = rem_q;
				sid_we = 1'b1;
				snx_we = 1'b1;
			end
			S_RW: begin
				if (!bm_rdata[limit_q[lobm_pkg::BIT_BITS-1:0]]) begin
					bm_we = 1'b1;
					bm_wa = {side_q, lim_row};
					bm_wd = bm_rdata |
						(lobm_pkg::WORD_BITS'(1) << limit_q[lobm_pkg::BIT_BITS-1:0]);
					lv_we = 1'b1;
					lv_wa = own_lv;
					lv_wd = '{head: nslot_q, tail: nslot_q};
				end
			end
			S_RL: begin
				snx_we = 1'b1;
				snx_wa = lv_rdata.tail;
				snx_wd = nslot_q;
				lv_we  = 1'b1;
				lv_wa  = own_lv;
				lv_wd  = '{head: lv_rdata.head, tail: nslot_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_wa] <= bm_wd;
		bm_rdata <= bm_mem[{bside_q, row_q}];
	end

	always_ff @(posedge clk) begin
		if (lv_we) lv_mem[lv_wa] <= lv_wd;
		lv_rdata <= lv_mem[lv_raddr];
	end

	always_ff @(posedge clk) begin
		if (sq_we) sq_mem[sq_wa] <= sq_wd;
		if (sid_we) sid_mem[ns] <= taker_q;
		if (snx_we) snx_mem[snx_wa] <= snx_wd;
		sq_rdata  <= sq_mem[slot_raddr];
		sid_rdata <= sid_mem[slot_raddr];
		snx_rdata <= snx_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[lobm_pkg::SLOT_BITS'(stk_cnt_q)] <= slot_q;
		stk_rdata <= stk_mem[stk_raddr];
	end

	// Sequencer. Each fill rescans the bitmap from the best price, so a level
	// emptied by the previous fill is skipped naturally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			next_id_q   <= '0;
			nfill_q     <= '0;
			stk_cnt_q   <= '0;
			fresh_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (results.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == lobm_pkg::BMA_BITS'(lobm_pkg::BM_ROWS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (orders.valid) begin
						next_id_q <= next_id_q + 1'b1;
						taker_q   <= next_id_q + 1'b1;
						side_q    <= orders.side;
						limit_q   <= orders.limit_price;
						rem_q     <= orders.order_quantity;
						nfill_q   <= '0;
						bside_q   <= ~orders.side;
						row_q     <= (orders.side == lobm_pkg::SIDE_SELL) ? '1 : '0;
						// A zero quantity order only takes an id.
						if (orders.order_quantity != '0) state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (pick.found) begin
						if (nfill_q == lobm_pkg::FILL_BITS'(lobm_pkg::MAX_FILLS)) begin
							fin_kind_q <= lobm_pkg::KIND_LIMIT;
							state_q    <= S_FIN;
						end else begin
							lv_q    <= {~side_q, row_q, pick.bit_idx};
							pbit_q  <= pick.bit_idx;
							word_q  <= bm_rdata;
							state_q <= S_LV;
						end
					end else if (row_q == lim_row) begin
						state_q <= S_RST;
					end else begin
						row_q   <= (side_q == lobm_pkg::SIDE_SELL) ? row_q - 1'b1 : row_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_LV: begin
					slot_q  <= lv_rdata.head;
					tail_q  <= lv_rdata.tail;
					state_q <= S_SL;
				end
				S_SL: begin
					if (oslot) begin
						res_kind_q  <= lobm_pkg::KIND_TRADE;
						res_tq_q    <= tq;
						res_tp_q    <= {row_q, pbit_q};
						res_maker_q <= sid_rdata;
						res_taker_q <= taker_q;
						res_rem_q   <= new_rem;
						res_last_q  <= (new_rem == '0);
						rem_q       <= new_rem;
						nfill_q     <= nfill_q + 1'b1;
						if (new_sq == '0) stk_cnt_q <= stk_cnt_q + 1'b1;
						row_q       <= start_row;
						state_q     <= (new_rem == '0) ? S_IDLE : S_SRD;
					end
				end
				S_RST: begin
					if (book_full) begin
						fin_kind_q <= lobm_pkg::KIND_FULL;
						state_q    <= S_FIN;
					end else begin
						bside_q <= side_q;
						row_q   <= lim_row;
						state_q <= S_RB;
					end
				end
				S_RB: begin
					nslot_q <= ns;
					if (stk_cnt_q != '0)
						stk_cnt_q <= stk_cnt_q - 1'b1;
					else
						fresh_q <= fresh_q + 1'b1;
					state_q <= S_RW;
				end
				S_RW: begin
					fin_kind_q <= lobm_pkg::KIND_REST;
					if (bm_rdata[limit_q[lobm_pkg::BIT_BITS-1:0]])
						state_q <= S_RL;
					else
						state_q <= S_FIN;
				end
				S_RL: state_q <= S_FIN;
				S_FIN: begin
					if (oslot) begin
						res_kind_q  <= fin_kind_q;
						res_tq_q    <= '0;
						res_tp_q    <= '0;
						res_maker_q <= '0;
						res_taker_q <= taker_q;
						res_rem_q   <= rem_q;
						res_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign orders.ready               = (state_q == S_IDLE);
	assign results.valid              = res_valid_q;
	assign results.kind               = res_kind_q;
	assign results.trade_quantity     = res_tq_q;
	assign results.trade_price        = res_tp_q;
	assign results.maker_order_id     = res_maker_q;
	assign results.taker_order_id     = res_taker_q;
	assign results.remaining_quantity = res_rem_q;
	assign results.last               = res_last_q;

	// Every slot on the free stack was once handed out from the fresh range.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= fresh_q)
		else $error("free stack holds more slots than were ever allocated");

	// Only trades may be followed by more results of the same order.
	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.kind != lobm_pkg::KIND_TRADE) |-> results.last)
		else $error("non-trade result without last");

	// The fill counter never passes the fill limit.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfill_q <= lobm_pkg::FILL_BITS'(lobm_pkg::MAX_FILLS))
		else $error("fill count beyond limit");

	// A stalled fill keeps its slot so the read data stay valid.
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SL) && !oslot |=> (state_q == S_SL) && $stable(slot_q))
		else $error("fill slot changed while stalled");

endmodule

// ===== rtl/lobm_bit_pick.sv =====
// ----------------------------------------------------------------------------
// Bitmap level picker
// Finds the best occupied level in one bitmap word within the limit price.
// ----------------------------------------------------------------------------
module lobm_bit_pick (
	input  logic [lobm_pkg::WORD_BITS-1:0]  word,
	input  logic                            sell,
	input  logic [lobm_pkg::ROW_BITS-1:0]   row,
	input  logic [lobm_pkg::PRICE_BITS-1:0] limit,
	output lobm_pkg::pick_t                 pick
);
	logic [lobm_pkg::ROW_BITS-1:0] lim_row;
	logic [lobm_pkg::BIT_BITS-1:0] lim_bit;
	logic [lobm_pkg::WORD_BITS-1:0] cand;

	assign lim_row = limit[lobm_pkg::PRICE_BITS-1:lobm_pkg::BIT_BITS];
	assign lim_bit = limit[lobm_pkg::BIT_BITS-1:0];

	// A buy takes levels at or below its limit, a sell at or above.
	always_comb begin
		for (int i = 0; i < lobm_pkg::WORD_BITS; i++) begin
			if (sell)
				cand[i] = word[i] && ((row > lim_row) ||
					(lobm_pkg::BIT_BITS'(i) >= lim_bit));
			else
				cand[i] = word[i] && ((row < lim_row) ||
					(lobm_pkg::BIT_BITS'(i) <= lim_bit));
		end
	end

	// Buys want the lowest price, sells the highest.
	always_comb begin
		pick.found   = |cand;
		pick.bit_idx = '0;
		if (sell) begin
			for (int i = 0; i < lobm_pkg::WORD_BITS; i++)
				if (cand[i]) pick.bit_idx = lobm_pkg::BIT_BITS'(i);
		end else begin
			for (int i = lobm_pkg::WORD_BITS - 1; i >= 0; i--)
				if (cand[i]) pick.bit_idx = lobm_pkg::BIT_BITS'(i);
		end
	end
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Order book matcher testbench
// Drives limit orders into the matcher and checks every trade and outcome
// against a behavioral order book kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                            side;
		logic [lobm_pkg::PRICE_BITS-1:0] price;
		logic [lobm_pkg::QTY_BITS-1:0]   qty;
	} order_t;

	typedef struct packed {
		logic [1:0]                      kind;
		logic [lobm_pkg::QTY_BITS-1:0]   trade_qty;
		logic [lobm_pkg::PRICE_BITS-1:0] trade_price;
		logic [lobm_pkg::ID_BITS-1:0]    maker;
		logic [lobm_pkg::ID_BITS-1:0]    taker;
		logic [lobm_pkg::QTY_BITS-1:0]   rem_qty;
		logic                            last;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lobm_order_if  orders();
	lobm_result_if results();

	limit_order_book_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.orders (orders),
		.results(results)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The book mirror: one FIFO of resting orders per side and price level.
	// Index side*PRICE_LEVELS+price, matching the block's level numbering.
	logic [lobm_pkg::ID_BITS-1:0]  book_id[2*lobm_pkg::PRICE_LEVELS][$];
	logic [lobm_pkg::QTY_BITS-1:0] book_qty[2*lobm_pkg::PRICE_LEVELS][$];
	logic [lobm_pkg::ID_BITS-1:0]  id_count = '0;
	int                            resting_count = 0;

	order_t   pending_orders[$];
	outcome_t expected_outcomes[$];

	// Idle percentages for the two sides; the stimulus process moves through phases.
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_sender = 1'b0;
	int  error_count = 0;

	// Works out every outcome of one order and updates the book mirror.
	function automatic void match_order(order_t o);
		logic [lobm_pkg::QTY_BITS-1:0] left;
		logic [lobm_pkg::ID_BITS-1:0]  taker;
		int                            fills;
		int                            p;
		int                            lv;
		int                            opp;
		bit                            found;
		bit                            limit_hit;
		outcome_t                      r;
		logic [lobm_pkg::QTY_BITS-1:0] tq;

		left = o.qty;
		id_count = id_count + 1;
		taker = id_count;
		fills = 0;
		limit_hit = 1'b0;
		if (left == 0)
			return;
		opp = (o.side == lobm_pkg::SIDE_BUY) ? lobm_pkg::PRICE_LEVELS : 0;
		while (left != 0) begin
			found = 1'b0;
			if (o.side == lobm_pkg::SIDE_BUY) begin
				for (p = 0; p <= int'(o.price); p++)
					if (book_id[opp + p].size() != 0) begin
						found = 1'b1;
						break;
					end
			end else begin
				for (p = lobm_pkg::PRICE_LEVELS - 1; p >= int'(o.price); p--)
					if (book_id[opp + p].size() != 0) begin
						found = 1'b1;
						break;
					end
			end
			if (!found)
				break;
			if (fills >= lobm_pkg::MAX_FILLS) begin
				limit_hit = 1'b1;
				break;
			end
			lv = opp + p;
			tq = (book_qty[lv][0] < left) ? book_qty[lv][0] : left;
			left -= tq;
			book_qty[lv][0] -= tq;
			r = '{lobm_pkg::KIND_TRADE, tq, lobm_pkg::PRICE_BITS'(p), book_id[lv][0], taker,
				left, 1'b0};
			if (left == 0)
				r.last = 1'b1;
			expected_outcomes.insert(expected_outcomes.size(), r);
			fills++;
			if (book_qty[lv][0] == 0) begin
				void'(book_id[lv].pop_front());
				void'(book_qty[lv].pop_front());
				resting_count--;
			end
		end
		if (left == 0)
			return;
		r = '{lobm_pkg::KIND_REST, '0, '0, '0, taker, left, 1'b1};
		if (limit_hit)
			r.kind = lobm_pkg::KIND_LIMIT;
		else if (resting_count >= lobm_pkg::ORDER_SLOTS)
			r.kind = lobm_pkg::KIND_FULL;
		else begin
			lv = int'(o.side) * lobm_pkg::PRICE_LEVELS + int'(o.price);
			book_id[lv].insert(book_id[lv].size(), taker);
			book_qty[lv].insert(book_qty[lv].size(), left);
			resting_count++;
		end
		expected_outcomes.insert(expected_outcomes.size(), r);
	endfunction

	// Driver: presents queued orders, idling at random by the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orders.valid <= 1'b0;
			orders.side <= 1'b0;
			orders.limit_price <= '0;
			orders.order_quantity <= '0;
		end else begin
			if (!orders.valid || orders.ready) begin
				if (orders.valid)
					match_order(pending_orders.pop_front());
				if (pending_orders.size() != 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					orders.valid <= 1'b1;
					{orders.side, orders.limit_price, orders.order_quantity} <=
						pending_orders[0];
				end else begin
					orders.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes results and compares each against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t exp_o;

		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				got = '{results.kind, results.trade_quantity, results.trade_price,
					results.maker_order_id, results.taker_order_id,
					results.remaining_quantity, results.last};
				if (expected_outcomes.size() == 0) begin
					$error("unexpected result item kind=%0d taker=%0d", got.kind, got.taker);
					error_count++;
				end else begin
					exp_o = expected_outcomes.pop_front();
					if (got.kind !== exp_o.kind) begin
						$error("kind: expected %0d, got %0d", exp_o.kind, got.kind);
						error_count++;
					end
					if (got.trade_qty !== exp_o.trade_qty) begin
						$error("trade_quantity: expected %0d, got %0d",
							exp_o.trade_qty, got.trade_qty);
						error_count++;
					end
					if (got.trade_price !== exp_o.trade_price) begin
						$error("trade_price: expected %0d, got %0d",
							exp_o.trade_price, got.trade_price);
						error_count++;
					end
					if (got.maker !== exp_o.maker) begin
						$error("maker_order_id: expected %0d, got %0d", exp_o.maker, got.maker);
						error_count++;
					end
					if (got.taker !== exp_o.taker) begin
						$error("taker_order_id: expected %0d, got %0d", exp_o.taker, got.taker);
						error_count++;
					end
					if (got.rem_qty !== exp_o.rem_qty) begin
						$error("remaining_quantity: expected %0d, got %0d",
							exp_o.rem_qty, got.rem_qty);
						error_count++;
					end
					if (got.last !== exp_o.last) begin
						$error("last: expected %0d, got %0d", exp_o.last, got.last);
						error_count++;
					end
				end
			end
			results.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic order_t make_order(logic s, int pr, int q);
		order_t o;

		o.side = s;
		o.price = lobm_pkg::PRICE_BITS'(pr);
		o.qty = lobm_pkg::QTY_BITS'(q);
		return o;
	endfunction

	// Appends one order to the queue that feeds the driver.
	function automatic void add_order(order_t o);
		pending_orders.insert(pending_orders.size(), o);
	endfunction

	// Random orders cluster around a mid price so that most of them cross or
	// rest close to the spread; a minority roam the whole field range.
	function automatic order_t random_order();
		order_t o;
		int     mid;

		mid = 500;
		o.side = 1'($urandom_range(1));
		if ($urandom_range(9) < 8) begin
			o.price = lobm_pkg::PRICE_BITS'(mid - 12 + $urandom_range(24));
			o.qty = lobm_pkg::QTY_BITS'($urandom_range(1, 400));
		end else begin
			o.price = lobm_pkg::PRICE_BITS'($urandom);
			o.qty = lobm_pkg::QTY_BITS'($urandom);
		end
		return o;
	endfunction

	task automatic wait_drained();
		while (pending_orders.size() != 0 || orders.valid || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int ph;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: zero quantity, field extremes, a deep sweep that hits
		// the fill limit, a full fill, partial fills and crossings at the edges.
		add_order(make_order(lobm_pkg::SIDE_BUY, 100, 0));
		add_order(make_order(lobm_pkg::SIDE_BUY, 0, 1));
		add_order(make_order(lobm_pkg::SIDE_SELL, 1023, 1048575));
		add_order(make_order(lobm_pkg::SIDE_SELL, 0, 1));
		add_order(make_order(lobm_pkg::SIDE_BUY, 1023, 1048575));
		for (i = 0; i < 70; i++)
			add_order(make_order(lobm_pkg::SIDE_SELL, 600 + (i % 5), 2));
		add_order(make_order(lobm_pkg::SIDE_BUY, 1023, 1048575));
		add_order(make_order(lobm_pkg::SIDE_BUY, 1023, 14));
		add_order(make_order(lobm_pkg::SIDE_SELL, 0, 1048575));
		add_order(make_order(lobm_pkg::SIDE_BUY, 300, 50));
		add_order(make_order(lobm_pkg::SIDE_SELL, 300, 20));
		add_order(make_order(lobm_pkg::SIDE_SELL, 299, 30));
		add_order(make_order(lobm_pkg::SIDE_BUY, 512, 699050));
		add_order(make_order(lobm_pkg::SIDE_SELL, 511, 349525));
		add_order(make_order(lobm_pkg::SIDE_SELL, 0, 1048575));

		// The stimulus waits until the book has answered everything, then holds the sender.
		hold_sender = 1'b0;
		wait_drained();
		hold_sender = 1'b1;
		repeat (40) @(posedge clk);
		hold_sender = 1'b0;

		// Random part in four idling phases.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 66 : (ph == 3 ? 9 : 0);
			recv_stall_pct = (ph == 2) ? 66 : 0;
			if (ph == 3) begin
				send_idle_pct = 9;
				recv_stall_pct = 9;
			end
			for (i = 0; i < 16; i++)
				add_order(random_order());
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
